[design/sai2x_pkg.sv]
// Shared types, constants and colour arithmetic for the 2xSaI pixel scaler.
// No dependencies; imported by every module of the block except sai2x_ram.
package sai2x_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIX_W   = 16;
   localparam int CFG_W   = 11;
   localparam int COORD_W = 10;
   localparam int IDX_W   = 2;

   localparam int NUM_BANKS = 8;
   localparam int BANK_W    = $clog2(NUM_BANKS);
   localparam int WIN_N     = 4;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd320;
   localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd200;

   typedef enum logic [IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_FORMAT = 2'd2
   } reg_idx_type;

   typedef enum logic {
      FMT_555 = 1'b0,
      FMT_565 = 1'b1
   } fmt_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      window_type         win;
      logic [COORD_W-1:0] qx;
      logic [COORD_W-1:0] qy;
      logic               last;
   } job_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } queue_status_type;

   function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] p,
                                             input logic [PIX_W-1:0] q,
                                             input fmt_type fmt);
      logic [5:0] rs;
      logic [6:0] gs;
      logic [5:0] bs;
      logic [PIX_W-1:0] res;
      bs = {1'b0, p[4:0]} + {1'b0, q[4:0]};
      if (fmt == FMT_565) begin
         rs  = {1'b0, p[15:11]} + {1'b0, q[15:11]};
         gs  = {1'b0, p[10:5]} + {1'b0, q[10:5]};
         res = {rs[5:1], gs[6:1], bs[5:1]};
      end else begin
         rs  = {1'b0, p[14:10]} + {1'b0, q[14:10]};
         gs  = {2'b0, p[9:5]} + {2'b0, q[9:5]};
         res = {1'b0, rs[5:1], gs[5:1], bs[5:1]};
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] p,
                                             input logic [PIX_W-1:0] q,
                                             input logic [PIX_W-1:0] s,
                                             input logic [PIX_W-1:0] t,
                                             input fmt_type fmt);
      logic [6:0] rs;
      logic [7:0] gs;
      logic [6:0] bs;
      logic [PIX_W-1:0] res;
      bs = {2'b0, p[4:0]} + {2'b0, q[4:0]} + {2'b0, s[4:0]} + {2'b0, t[4:0]};
      if (fmt == FMT_565) begin
         rs  = {2'b0, p[15:11]} + {2'b0, q[15:11]} + {2'b0, s[15:11]} + {2'b0, t[15:11]};
         gs  = {2'b0, p[10:5]} + {2'b0, q[10:5]} + {2'b0, s[10:5]} + {2'b0, t[10:5]};
         res = {rs[6:2], gs[7:2], bs[6:2]};
      end else begin
         rs  = {2'b0, p[14:10]} + {2'b0, q[14:10]} + {2'b0, s[14:10]} + {2'b0, t[14:10]};
         gs  = {3'b0, p[9:5]} + {3'b0, q[9:5]} + {3'b0, s[9:5]} + {3'b0, t[9:5]};
         res = {1'b0, rs[6:2], gs[6:2], bs[6:2]};
      end
      return res;
   endfunction

   // +1 when both c and d match b but not a, -1 when both match a
   function automatic logic signed [1:0] vote(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d);
      logic both_a;
      logic both_b;
      logic signed [1:0] res;
      both_a = (a == c) && (a == d);
      both_b = (b == c) && (a != c) && (b == d) && (a != d);
      if (both_b) res = 2'sd1;
      else if (both_a) res = -2'sd1;
      else res = 2'sd0;
      return res;
   endfunction

endpackage

[design/sai2x_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on a shared address. No dependencies.
module sai2x_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/sai2x_front.sv]
// Front end: configuration, frame counters, banked line stores and window fetch.
// Depends on sai2x_pkg and sai2x_ram; pushes one job per quad into the queue.
module sai2x_front
   import sai2x_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_command,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             csr_write,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data,
   input  queue_status_type q_status,
   output logic             job_push,
   output job_type          job,
   output fmt_type          fmt
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int DW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT) + 1;
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   fmt_type          fmt_ff, fmt_in;
   logic [CW-1:0]    in_col_ff, in_col_in;
   logic [RW-1:0]    in_row_ff, in_row_in;
   logic [CW-1:0]    out_col_ff, out_col_in;
   logic [RW-1:0]    out_row_ff, out_row_in;
   logic [PW-1:0]    pix_cnt_ff, pix_cnt_in;

   logic             s1_valid_ff;
   logic [COORD_W-1:0] s1_qx_ff, s1_qy_ff;
   logic             s1_last_ff;
   logic [BANK_W-1:0] s1_rsel_ff [WIN_N];

   logic [DW-1:0] w_eff, wm1, c2, c3;
   logic [RW-1:0] h_eff, hm1, r2, r3;
   logic [PW-1:0] thr;
   logic          accept, pix_ok, emit, last;
   logic [CW-1:0] col_rd [WIN_N];
   logic [RW-1:0] row_rd [WIN_N];
   logic [PIX_W-1:0] rd_data [NUM_BANKS][WIN_N];

   always_comb begin
      if (width_ff == '0) w_eff = DW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = DW'(MAX_WIDTH);
      else w_eff = DW'(width_ff);
      if (height_ff == '0) h_eff = RW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_ff);
   end

   assign wm1 = w_eff - DW'(1);
   assign hm1 = h_eff - RW'(1);
   assign thr = (PW'(w_eff) << 1) + PW'(2);

   assign req_full = (QCNT_W'(s1_valid_ff) + q_status.count) >= QCNT_W'(QDEPTH);
   assign accept   = req_push && !req_full;
   assign pix_ok   = accept && (req_command == CMD_PIXEL) && (in_row_ff < h_eff);
   assign last     = (out_row_ff == hm1) && ({1'b0, out_col_ff} == wm1);

   always_comb begin
      if (pix_ok) emit = pix_cnt_ff >= thr;
      else emit = accept && (req_command == CMD_DRAIN) && (in_row_ff >= h_eff)
                  && (out_row_ff < h_eff);
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      fmt_in     = fmt_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pix_cnt_in = pix_cnt_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            REG_FORMAT: fmt_in    = fmt_type'(csr_data[0]);
            default: ;
         endcase
         if (csr_index == REG_WIDTH || csr_index == REG_HEIGHT
             || csr_index == REG_FORMAT) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            pix_cnt_in = '0;
         end
      end else begin
         if (pix_ok) begin
            pix_cnt_in = pix_cnt_ff + PW'(1);
            if ({1'b0, in_col_ff} == wm1) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               pix_cnt_in = '0;
            end else if ({1'b0, out_col_ff} == wm1) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   // clamp the window to the frame edges
   assign c2 = {1'b0, out_col_ff} + DW'(1);
   assign c3 = {1'b0, out_col_ff} + DW'(2);
   assign r2 = out_row_ff + RW'(1);
   assign r3 = out_row_ff + RW'(2);

   always_comb begin
      col_rd[0] = (out_col_ff == '0) ? '0 : out_col_ff - CW'(1);
      col_rd[1] = out_col_ff;
      col_rd[2] = (c2 > wm1) ? wm1[CW-1:0] : c2[CW-1:0];
      col_rd[3] = (c3 > wm1) ? wm1[CW-1:0] : c3[CW-1:0];
      row_rd[0] = (out_row_ff == '0) ? '0 : out_row_ff - RW'(1);
      row_rd[1] = out_row_ff;
      row_rd[2] = (r2 > hm1) ? hm1 : r2;
      row_rd[3] = (r3 > hm1) ? hm1 : r3;
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      for (genvar j = 0; j < WIN_N; j++) begin : g_copy
         sai2x_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
         ) u_ram (
            .clock  (clock),
            .wr_en  (pix_ok && (in_row_ff[BANK_W-1:0] == BANK_W'(b))),
            .wr_addr(in_col_ff),
            .wr_data(req_pixel),
            .rd_addr(col_rd[j]),
            .rd_data(rd_data[b][j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_WIDTH;
         height_ff   <= RST_HEIGHT;
         fmt_ff      <= FMT_565;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pix_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         fmt_ff      <= fmt_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pix_cnt_ff  <= pix_cnt_in;
         s1_valid_ff <= emit && !csr_write;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_qx_ff   <= COORD_W'(out_col_ff);
         s1_qy_ff   <= COORD_W'(out_row_ff);
         s1_last_ff <= last;
         for (int i = 0; i < WIN_N; i++) begin
            s1_rsel_ff[i] <= row_rd[i][BANK_W-1:0];
         end
      end
   end

   always_comb begin
      job.qx   = s1_qx_ff;
      job.qy   = s1_qy_ff;
      job.last = s1_last_ff;
      for (int i = 0; i < WIN_N; i++) begin
         for (int j = 0; j < WIN_N; j++) begin
            job.win[i][j] = rd_data[s1_rsel_ff[i]][j];
         end
      end
   end

   assign job_push = s1_valid_ff;
   assign fmt      = fmt_ff;
endmodule

[design/sai2x_queue.sv]
// Short job queue between the front end and the quad builder.
// Depends on sai2x_pkg for the job type and depth.
module sai2x_queue
   import sai2x_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);
   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
endmodule

[design/sai2x_back.sv]
// Back end: applies the 2xSaI rules to a fetched window and holds the result word.
// Depends on sai2x_pkg for the job type and colour functions.
module sai2x_back
   import sai2x_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  job_type            head,
   input  queue_status_type   q_status,
   input  fmt_type            fmt,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [COORD_W-1:0] rsp_quad_x,
   output logic [COORD_W-1:0] rsp_quad_y,
   output logic [PIX_W-1:0]   rsp_top_left,
   output logic [PIX_W-1:0]   rsp_top_right,
   output logic [PIX_W-1:0]   rsp_bottom_left,
   output logic [PIX_W-1:0]   rsp_bottom_right,
   output logic               rsp_last_quad
);
   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic [PIX_W-1:0]   tl_ff, tr_ff, bl_ff, br_ff;
   logic               last_ff;
   logic               load;

   logic [PIX_W-1:0] pi, pe, pf, pj, pg, pa, pb, pk, ph, pc, pd, pl, pm, pn, po;
   logic [PIX_W-1:0] right, below, diag;
   logic signed [3:0] score;

   assign load  = !q_status.empty && (!valid_ff || rsp_pop);
   assign q_pop = load;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_pop) valid_in = 1'b0;
   end

   assign {pi, pe, pf, pj} = {head.win[0][0], head.win[0][1], head.win[0][2], head.win[0][3]};
   assign {pg, pa, pb, pk} = {head.win[1][0], head.win[1][1], head.win[1][2], head.win[1][3]};
   assign {ph, pc, pd, pl} = {head.win[2][0], head.win[2][1], head.win[2][2], head.win[2][3]};
   assign {pm, pn, po}     = {head.win[3][0], head.win[3][1], head.win[3][2]};

   always_comb begin
      score = 4'(vote(pa, pb, pg, pe)) - 4'(vote(pb, pa, pk, pf))
            - 4'(vote(pb, pa, ph, pn)) + 4'(vote(pa, pb, pl, po));
      if (pa == pd && pb != pc) begin
         if ((pa == pe && pb == pl) || (pa == pc && pa == pf && pb != pe && pb == pj))
            right = pa;
         else
            right = avg2(pa, pb, fmt);
         if ((pa == pg && pc == po) || (pa == pb && pa == ph && pg != pc && pc == pm))
            below = pa;
         else
            below = avg2(pa, pc, fmt);
         diag = pa;
      end else if (pb == pc && pa != pd) begin
         if ((pb == pf && pa == ph) || (pb == pe && pb == pd && pa != pf && pa == pi))
            right = pb;
         else
            right = avg2(pa, pb, fmt);
         if ((pc == ph && pa == pf) || (pc == pg && pc == pd && pa != ph && pa == pi))
            below = pc;
         else
            below = avg2(pa, pc, fmt);
         diag = pb;
      end else if (pa == pd && pb == pc) begin
         if (pa == pb) begin
            right = pa;
            below = pa;
            diag  = pa;
         end else begin
            right = avg2(pa, pb, fmt);
            below = avg2(pa, pc, fmt);
            if (score > 4'sd0) diag = pa;
            else if (score < 4'sd0) diag = pb;
            else diag = avg4(pa, pb, pc, pd, fmt);
         end
      end else begin
         diag = avg4(pa, pb, pc, pd, fmt);
         if (pa == pc && pa == pf && pb != pe && pb == pj) right = pa;
         else if (pb == pe && pb == pd && pa != pf && pa == pi) right = pb;
         else right = avg2(pa, pb, fmt);
         if (pa == pb && pa == ph && pg != pc && pc == pm) below = pa;
         else if (pc == pg && pc == pd && pa != ph && pa == pi) below = pc;
         else below = avg2(pa, pc, fmt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         qx_ff   <= head.qx;
         qy_ff   <= head.qy;
         tl_ff   <= pa;
         tr_ff   <= right;
         bl_ff   <= below;
         br_ff   <= diag;
         last_ff <= head.last;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_quad_x       = qx_ff;
   assign rsp_quad_y       = qy_ff;
   assign rsp_top_left     = tl_ff;
   assign rsp_top_right    = tr_ff;
   assign rsp_bottom_left  = bl_ff;
   assign rsp_bottom_right = br_ff;
   assign rsp_last_quad    = last_ff;
endmodule

[design/sai_2x_pixel_scaler.sv]
// 2xSaI scaler: one source word in, one 2x2 quad word out per clock unless stalled.
// The quad of pixel q is fetched when pixel q + 2*width + 2 is taken, then queued
// and held as the result word. Throughput is one word per cycle, set by the single
// write port of each line store. Synchronous active-high reset clears counters,
// registers and queue, not line stores. Depends on sai2x_pkg, front, queue and back.
module sai_2x_pixel_scaler
   import sai2x_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_command,
   input  logic [PIX_W-1:0]   req_pixel,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [COORD_W-1:0] rsp_quad_x,
   output logic [COORD_W-1:0] rsp_quad_y,
   output logic [PIX_W-1:0]   rsp_top_left,
   output logic [PIX_W-1:0]   rsp_top_right,
   output logic [PIX_W-1:0]   rsp_bottom_left,
   output logic [PIX_W-1:0]   rsp_bottom_right,
   output logic               rsp_last_quad,
   input  logic               csr_write,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]   csr_data
);
   queue_status_type q_status;
   logic             job_push, q_pop;
   job_type          job, head;
   fmt_type          fmt;

   sai2x_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_command(req_command),
      .req_pixel  (req_pixel),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .job_push   (job_push),
      .job        (job),
      .fmt        (fmt)
   );

   sai2x_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .push_job(job),
      .pop     (q_pop),
      .head    (head),
      .status  (q_status)
   );

   sai2x_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .fmt             (fmt),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_quad_x      (rsp_quad_x),
      .rsp_quad_y      (rsp_quad_y),
      .rsp_top_left    (rsp_top_left),
      .rsp_top_right   (rsp_top_right),
      .rsp_bottom_left (rsp_bottom_left),
      .rsp_bottom_right(rsp_bottom_right),
      .rsp_last_quad   (rsp_last_quad)
   );
endmodule

[design/sai2x_checker.sv]
// Port-level checks for the 2xSaI scaler, bound to the top level.
// Depends on sai2x_pkg for port widths.
module sai2x_checker
   import sai2x_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [COORD_W-1:0] rsp_quad_x,
   input logic [COORD_W-1:0] rsp_quad_y,
   input logic [PIX_W-1:0]   rsp_top_left,
   input logic [PIX_W-1:0]   rsp_top_right,
   input logic [PIX_W-1:0]   rsp_bottom_left,
   input logic [PIX_W-1:0]   rsp_bottom_right,
   input logic               rsp_last_quad
);
   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("not empty and ready after reset");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_quad_x)
         && $stable(rsp_quad_y) && $stable(rsp_top_left) && $stable(rsp_top_right)
         && $stable(rsp_bottom_left) && $stable(rsp_bottom_right)
         && $stable(rsp_last_quad))
      else $error("result word changed while stalled");

   a_full_has_word: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled with no result word shown");
endmodule

bind sai_2x_pixel_scaler sai2x_checker u_sai2x_checker (.*);

[test/sai_2x_pixel_scaler_tb.sv]
// Self-checking 2xSaI scaler testbench: directed table, fixed-size frames, random frames.
// Holds its own quad predictor and line store copy; depends on sai2x_pkg and the RTL.
module sai_2x_pixel_scaler_tb;
   import sai2x_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PIX_W-1:0]   tl;
      logic [PIX_W-1:0]   tr;
      logic [PIX_W-1:0]   bl;
      logic [PIX_W-1:0]   br;
      logic               last;
   } quad_word_type;

   typedef struct {
      bit               is_cfg;
      reg_idx_type      idx;
      int               val;
      cmd_type          cmd;
      logic [PIX_W-1:0] pix;
      bit               typed;
      logic [PIX_W-1:0] tpix;
      bit               tlast;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic               req_command;
   logic [PIX_W-1:0]   req_pixel;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [COORD_W-1:0] rsp_quad_x;
   logic [COORD_W-1:0] rsp_quad_y;
   logic [PIX_W-1:0]   rsp_top_left;
   logic [PIX_W-1:0]   rsp_top_right;
   logic [PIX_W-1:0]   rsp_bottom_left;
   logic [PIX_W-1:0]   rsp_bottom_right;
   logic               rsp_last_quad;
   logic               csr_write;
   logic [IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]   csr_data;

   sai_2x_pixel_scaler u_dut (.*);

   logic [PIX_W-1:0] pix_mem [4096];
   int               in_col, in_row, out_col, out_row;
   int               width_reg, height_reg;
   fmt_type          fmt_reg;
   bit               frame_done;
   quad_word_type    quad_q[$];
   quad_word_type    rx_word;
   int               errs, items;
   bit               calm, hold_start;
   int               hold_left, stall_left;
   logic [PIX_W-1:0] palette [4];

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int eff_size(int v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] fetch(int x, int y, int w, int h);
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x > w - 1) x = w - 1;
      if (y > h - 1) y = h - 1;
      return pix_mem[(y * w + x) % 4096];
   endfunction

   function automatic void split_rgb(logic [PIX_W-1:0] p, output int r, output int g,
                                     output int b);
      if (fmt_reg == FMT_565) begin
         r = p[15:11]; g = p[10:5];
      end else begin
         r = p[14:10]; g = p[9:5];
      end
      b = p[4:0];
   endfunction

   function automatic logic [PIX_W-1:0] pack_rgb(int r, int g, int b);
      logic [PIX_W-1:0] v;
      v = '0;
      if (fmt_reg == FMT_565) v = {r[4:0], g[5:0], b[4:0]};
      else v = {1'b0, r[4:0], g[4:0], b[4:0]};
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] mix2(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
      int r0, g0, b0, r1, g1, b1;
      split_rgb(p, r0, g0, b0);
      split_rgb(q, r1, g1, b1);
      return pack_rgb((r0 + r1) >> 1, (g0 + g1) >> 1, (b0 + b1) >> 1);
   endfunction

   function automatic logic [PIX_W-1:0] mix4(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q,
                                             logic [PIX_W-1:0] s, logic [PIX_W-1:0] t);
      int r0, g0, b0, r1, g1, b1, r2, g2, b2, r3, g3, b3;
      split_rgb(p, r0, g0, b0);
      split_rgb(q, r1, g1, b1);
      split_rgb(s, r2, g2, b2);
      split_rgb(t, r3, g3, b3);
      return pack_rgb((r0 + r1 + r2 + r3) >> 2, (g0 + g1 + g2 + g3) >> 2,
                      (b0 + b1 + b2 + b3) >> 2);
   endfunction

   function automatic int tally(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                logic [PIX_W-1:0] c, logic [PIX_W-1:0] d);
      int x, y;
      x = int'(a == c) + int'(a == d);
      y = int'(b == c && a != c) + int'(b == d && a != d);
      return (y >> 1) - (x >> 1);
   endfunction

   function automatic quad_word_type build_quad(int x, int y, int w, int h);
      quad_word_type q;
      logic [PIX_W-1:0] pi, pe, pf, pj, pg, pa, pb, pk, ph, pc, pd, pl, pm, pn, po;
      logic [PIX_W-1:0] rt, bw, dg;
      int score;
      pi = fetch(x-1, y-1, w, h); pe = fetch(x, y-1, w, h);
      pf = fetch(x+1, y-1, w, h); pj = fetch(x+2, y-1, w, h);
      pg = fetch(x-1, y, w, h);   pa = fetch(x, y, w, h);
      pb = fetch(x+1, y, w, h);   pk = fetch(x+2, y, w, h);
      ph = fetch(x-1, y+1, w, h); pc = fetch(x, y+1, w, h);
      pd = fetch(x+1, y+1, w, h); pl = fetch(x+2, y+1, w, h);
      pm = fetch(x-1, y+2, w, h); pn = fetch(x, y+2, w, h);
      po = fetch(x+1, y+2, w, h);
      if (pa == pd && pb != pc) begin
         if ((pa == pe && pb == pl) || (pa == pc && pa == pf && pb != pe && pb == pj)) rt = pa;
         else rt = mix2(pa, pb);
         if ((pa == pg && pc == po) || (pa == pb && pa == ph && pg != pc && pc == pm)) bw = pa;
         else bw = mix2(pa, pc);
         dg = pa;
      end else if (pb == pc && pa != pd) begin
         if ((pb == pf && pa == ph) || (pb == pe && pb == pd && pa != pf && pa == pi)) rt = pb;
         else rt = mix2(pa, pb);
         if ((pc == ph && pa == pf) || (pc == pg && pc == pd && pa != ph && pa == pi)) bw = pc;
         else bw = mix2(pa, pc);
         dg = pb;
      end else if (pa == pd && pb == pc) begin
         if (pa == pb) begin
            rt = pa; bw = pa; dg = pa;
         end else begin
            bw = mix2(pa, pc);
            rt = mix2(pa, pb);
            score = tally(pa, pb, pg, pe) - tally(pb, pa, pk, pf)
                  - tally(pb, pa, ph, pn) + tally(pa, pb, pl, po);
            if (score > 0) dg = pa;
            else if (score < 0) dg = pb;
            else dg = mix4(pa, pb, pc, pd);
         end
      end else begin
         dg = mix4(pa, pb, pc, pd);
         if (pa == pc && pa == pf && pb != pe && pb == pj) rt = pa;
         else if (pb == pe && pb == pd && pa != pf && pa == pi) rt = pb;
         else rt = mix2(pa, pb);
         if (pa == pb && pa == ph && pg != pc && pc == pm) bw = pa;
         else if (pc == pg && pc == pd && pa != ph && pa == pi) bw = pc;
         else bw = mix2(pa, pc);
      end
      q.x = x[COORD_W-1:0]; q.y = y[COORD_W-1:0];
      q.tl = pa; q.tr = rt; q.bl = bw; q.br = dg; q.last = 0;
      return q;
   endfunction

   task automatic emit_quad(int w, int h, output quad_word_type q);
      bit last;
      last = (out_row == h - 1) && (out_col == w - 1);
      q = build_quad(out_col, out_row, w, h);
      q.last = last;
      if (last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         frame_done = 1;
      end else if (++out_col >= w) begin
         out_col = 0;
         out_row++;
      end
   endtask

   task automatic predict_quad(cmd_type c, logic [PIX_W-1:0] p, output bit got,
                               output quad_word_type q);
      int w, h, lin;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      got = 0;
      if (c == CMD_PIXEL) begin
         if (in_row >= h) return;
         lin = in_row * w + in_col;
         pix_mem[lin % 4096] = p;
         if (++in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (lin >= 2 * w + 2) begin
            emit_quad(w, h, q);
            got = 1;
         end
      end else if (in_row >= h && out_row < h) begin
         emit_quad(w, h, q);
         got = 1;
      end
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (quad_q.size() == 0) begin
            $error("quad word with nothing expected");
            errs++;
         end else begin
            rx_word = quad_q.pop_front();
            check_field("quad_x", rx_word.x, rsp_quad_x);
            check_field("quad_y", rx_word.y, rsp_quad_y);
            check_field("top_left", rx_word.tl, rsp_top_left);
            check_field("top_right", rx_word.tr, rsp_top_right);
            check_field("bottom_left", rx_word.bl, rsp_bottom_left);
            check_field("bottom_right", rx_word.br, rsp_bottom_right);
            check_field("last_quad", rx_word.last, rsp_last_quad);
         end
      end
      if (hold_start) begin
         hold_left = 400;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (!calm) stall_left = gap_len();
      end
   end

   task automatic send_word(cmd_type c, logic [PIX_W-1:0] p, bit typed = 0,
                            logic [PIX_W-1:0] tpix = '0, bit tlast = 0);
      bit got;
      quad_word_type q;
      int g;
      req_push <= 1'b1;
      req_command <= c;
      req_pixel <= p;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_quad(c, p, got, q);
      if (got) begin
         if (typed) q = '{0, 0, tpix, tpix, tpix, tpix, tlast};
         quad_q.push_back(q);
      end
      items++;
      g = calm ? 0 : gap_len();
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (quad_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type i, int v);
      csr_write <= 1'b1;
      csr_index <= i;
      csr_data <= v[CFG_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (i)
         REG_WIDTH:  width_reg = v & 'h7FF;
         REG_HEIGHT: height_reg = v & 'h7FF;
         default:    fmt_reg = fmt_type'(v[0]);
      endcase
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_done = 0;
      @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel();
      if ($urandom_range(0, 99) < 80) return palette[$urandom_range(0, 3)];
      return PIX_W'($urandom());
   endfunction

   task automatic run_frame(int w_raw, int h_raw, bit broken);
      int total, n;
      wait_idle();
      write_reg(REG_WIDTH, w_raw);
      write_reg(REG_HEIGHT, h_raw);
      write_reg(REG_FORMAT, $urandom_range(0, 1));
      for (int k = 0; k < 4; k++) palette[k] = PIX_W'($urandom());
      total = eff_size(w_raw) * eff_size(h_raw);
      if (total < 2) broken = 0;
      n = broken ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4) send_word(CMD_DRAIN, PIX_W'($urandom()));
         send_word(CMD_PIXEL, pick_pixel());
      end
      if (!broken) begin
         if ($urandom_range(0, 1)) send_word(CMD_PIXEL, PIX_W'($urandom()));
         while (!frame_done) send_word(CMD_DRAIN, PIX_W'($urandom()));
         if ($urandom_range(0, 1)) send_word(CMD_DRAIN, PIX_W'($urandom()));
      end
   endtask

   stim_row_type dir_rows[] = '{
      '{1, REG_WIDTH,  1, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{1, REG_HEIGHT, 1, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{1, REG_FORMAT, 1, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'hFFFF, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 1, 16'hFFFF, 1},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'hFFFF, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 1, 16'h0000, 1},
      '{1, REG_FORMAT, 0, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h7FFF, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 1, 16'h7FFF, 1},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h8000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 1, 16'h8000, 1},
      '{1, REG_WIDTH,  0, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h5A5A, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 1, 16'h5A5A, 1},
      '{1, REG_WIDTH,  2, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{1, REG_HEIGHT, 2, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'hFFFF, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'hFFFF, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_PIXEL, 16'h1234, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0},
      '{0, REG_WIDTH,  0, CMD_DRAIN, 16'h0000, 0, 16'h0000, 0}
   };

   initial begin
      reset = 1'b1;
      req_push = 1'b0; req_command = 1'b0; req_pixel = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0; csr_index = '0; csr_data = '0;
      errs = 0; items = 0; calm = 0; hold_start = 0; hold_left = 0; stall_left = 0;
      width_reg = 320; height_reg = 200; fmt_reg = FMT_565;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_done = 0;
      for (int k = 0; k < 4096; k++) pix_mem[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            wait_idle();
            write_reg(dir_rows[i].idx, dir_rows[i].val);
         end else begin
            send_word(dir_rows[i].cmd, dir_rows[i].pix, dir_rows[i].typed,
                      dir_rows[i].tpix, dir_rows[i].tlast);
         end
      end

      run_frame(0, 2047, 0);
      run_frame(3, 0, 0);
      calm = 1;
      hold_start = 1;
      run_frame(16, 16, 0);
      calm = 0;

      while (items < 1900) begin
         calm = ($urandom_range(0, 99) < 20);
         if ($urandom_range(0, 99) < 90)
            run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 99) < 15);
         else
            run_frame($urandom_range(13, 40), $urandom_range(1, 4), 0);
      end
      calm = 0;

      wait_idle();
      repeat (20) @(posedge clock);
      if (errs == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
design/sai2x_pkg.sv
design/sai2x_ram.sv
design/sai2x_front.sv
design/sai2x_queue.sv
design/sai2x_back.sv
design/sai_2x_pixel_scaler.sv
design/sai2x_checker.sv
test/sai_2x_pixel_scaler_tb.sv
